>>> design/g2r_pkg.sv
// ----------------------------------------------------------------------------
// g2r_pkg: shared types and constants of the glob to regex translator
// Scan phase encoding, status codes, character codes and the result bundle
// passed from the translation logic to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package g2r_pkg;

  // Result burst length: the longest answer is "[.[.]" plus one byte
  localparam int unsigned MaxBytes = 6;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // Scan phase, one-hot
  typedef enum logic [4:0] {
    PH_NORMAL = 5'b00001,  // outside any bracket
    PH_ESCAPE = 5'b00010,  // backslash seen, next byte is quoted
    PH_OPEN   = 5'b00100,  // right after the opening '['
    PH_IN     = 5'b01000,  // inside a bracket
    PH_HELD   = 5'b10000   // inside a bracket, inner '[' held back
  } phase_e;

  // Status / sticky error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BRACKET = 2'd1;
  localparam logic [1:0] ERR_ESCAPE  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;

  // Everything one input item causes: the bytes to emit and the next state
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;   // bytes[0] goes out first
    logic [CntW-1:0]          cnt;     // number of results, 0 to MaxBytes
    logic                     bvalid;  // results carry bytes
    logic                     done;    // status result for the end marker
    logic [1:0]               status;
    phase_e                   phase;   // next scan phase
    logic [1:0]               err;     // next sticky error
  } xlate_t;

endpackage

`default_nettype wire

>>> design/g2r_xlate.sv
// ----------------------------------------------------------------------------
// g2r_xlate: translation of one pattern item
// Combinational: from the scan state, the mode and one item, form the
// result burst and the next scan state.
// ----------------------------------------------------------------------------
`default_nettype none

module g2r_xlate (
  input  g2r_pkg::phase_e phase_i,
  input  logic [1:0]      err_i,
  input  logic            mode_i,
  input  logic [7:0]      byte_i,
  input  logic            eom_i,
  output g2r_pkg::xlate_t res_o
);
  import g2r_pkg::*;

  // Bracket body byte; lead puts a held '[' ahead of it
  function automatic xlate_t in_bracket(xlate_t r_in, logic lead, logic [7:0] c);
    xlate_t          r;
    logic [2:0]      k;
    r = r_in;
    k = {2'b00, lead};
    if (lead) begin
      r.bytes[0] = CH_LBRACK;
    end
    if (c == CH_RBRACK) begin
      r.bytes[k] = c;
      r.cnt      = CntW'(k + 3'd1);
      r.phase    = PH_NORMAL;
    end else if (c == CH_LBRACK) begin
      r.cnt      = CntW'(k);
      r.phase    = PH_HELD;
    end else begin
      r.bytes[k] = c;
      r.cnt      = CntW'(k + 3'd1);
      r.phase    = PH_IN;
    end
    return r;
  endfunction

  always_comb begin
    xlate_t     r;
    logic [1:0] e;
    r       = '0;
    r.phase = phase_i;
    r.err   = err_i;
    e       = err_i;
    if (eom_i) begin
      if (err_i == ERR_NONE) begin
        if (phase_i == PH_OPEN || phase_i == PH_IN || phase_i == PH_HELD) begin
          e = ERR_BRACKET;
        end else if (phase_i == PH_ESCAPE) begin
          e = ERR_ESCAPE;
        end
      end
      r.cnt    = CntW'(1);
      r.done   = 1'b1;
      r.status = e;
      r.phase  = PH_NORMAL;
      r.err    = ERR_NONE;
    end else if (err_i != ERR_NONE) begin
      // drop bytes until the end marker
      r.cnt = '0;
    end else if (!mode_i) begin
      r.bytes[0] = byte_i;
      r.cnt      = CntW'(1);
      r.bvalid   = 1'b1;
    end else begin
      r.bvalid = 1'b1;
      case (phase_i)
        PH_ESCAPE: begin
          r.bytes[0] = CH_BSLASH;
          r.bytes[1] = byte_i;
          r.cnt      = CntW'(2);
          r.phase    = PH_NORMAL;
        end
        PH_OPEN: begin
          if (byte_i == CH_RBRACK) begin
            r.err = ERR_BRACKET;
          end else begin
            r = in_bracket(r, 1'b0, byte_i);
          end
        end
        PH_IN: begin
          r = in_bracket(r, 1'b0, byte_i);
        end
        PH_HELD: begin
          if (byte_i inside {CH_DOT, CH_EQ, CH_COLON}) begin
            r.bytes[0] = CH_LBRACK;
            r.bytes[1] = CH_DOT;
            r.bytes[2] = CH_LBRACK;
            r.bytes[3] = CH_DOT;
            r.bytes[4] = CH_RBRACK;
            r.bytes[5] = byte_i;
            r.cnt      = CntW'(6);
            r.phase    = PH_IN;
          end else begin
            r = in_bracket(r, 1'b1, byte_i);
          end
        end
        default: begin
          r.phase = PH_NORMAL;
          if (byte_i == CH_QMARK) begin
            r.bytes[0] = CH_DOT;
            r.cnt      = CntW'(1);
          end else if (byte_i == CH_STAR) begin
            r.bytes[0] = CH_DOT;
            r.bytes[1] = CH_STAR;
            r.cnt      = CntW'(2);
          end else if (byte_i == CH_LBRACK) begin
            r.bytes[0] = CH_LBRACK;
            r.cnt      = CntW'(1);
            r.phase    = PH_OPEN;
          end else if (byte_i == CH_BSLASH) begin
            r.cnt      = '0;
            r.phase    = PH_ESCAPE;
          end else if (byte_i inside {CH_CARET, CH_DOT, CH_DOLLAR, CH_LPAREN,
                                      CH_RPAREN, CH_PIPE, CH_PLUS, CH_LBRACE}) begin
            r.bytes[0] = CH_BSLASH;
            r.bytes[1] = byte_i;
            r.cnt      = CntW'(2);
          end else begin
            r.bytes[0] = byte_i;
            r.cnt      = CntW'(1);
          end
        end
      endcase
    end
    res_o = r;
  end

endmodule

`default_nettype wire

>>> design/glob_to_regex_translator.sv
// ----------------------------------------------------------------------------
// glob_to_regex_translator: shell wildcard to extended regex, byte stream
// Translates a wildcard pattern, fed one byte per transfer, into the bytes
// of the equivalent regular expression.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: one transfer per pattern byte (tdata); a transfer with tlast
//   high is the end marker of the pattern and its tdata is ignored.
//   Master side: one transfer per result. A byte result has tuser[0] high;
//   the end marker is answered by one status result (tuser[1] high, status
//   in tuser[3:2], tdata zero). tlast marks the last result of each input
//   transfer.
//   cfg_we_i/cfg_wdata_i write wildcard_mode (1 translate, 0 copy through);
//   write only while the block is idle.
// Latency and throughput:
//   Results of an accepted transfer appear on the master side in the next
//   cycle. The output drains one result per cycle while m_axis_tready is
//   high, a transfer having 0 to 6 results; single-result bytes stream at
//   one per cycle while the receiver is ready. An input that causes no
//   result (a backslash, an inner '[', bytes after an error) still takes
//   one slot of the input handshake.
// Reset: wildcard mode on, scan phase normal, no error, output empty.
// Stall: while the receiver holds m_axis_tready low the current result
//   holds and s_axis_tready stays low as long as any result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_to_regex_translator (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // wildcard_mode
  // pattern input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pattern_byte
  input  logic       s_axis_tlast,   // end_marker
  // regex output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser,   // [0] byte_valid, [1] done_res, [3:2] status
  output logic       m_axis_tlast    // run_last
);
  import g2r_pkg::*;

  logic                     mode_q;
  phase_e                   phase_q;
  logic [1:0]               err_q;
  logic [CntW-1:0]          rem_q, rem_d;
  logic [MaxBytes-1:0][7:0] buf_q;
  logic                     bvalid_q, done_q;
  logic [1:0]               status_q;

  xlate_t res;
  logic   s_xfer, m_xfer, load;

  g2r_xlate u_xlate (
    .phase_i (phase_q),
    .err_i   (err_q),
    .mode_i  (mode_q),
    .byte_i  (s_axis_tdata),
    .eom_i   (s_axis_tlast),
    .res_o   (res)
  );

  // Accept when the output register is empty or its last result leaves now
  assign s_axis_tready = (rem_q == '0) || ((rem_q == CntW'(1)) && m_axis_tready);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  assign load          = s_xfer && (res.cnt != '0);

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = res.cnt;
    end else if (m_xfer) begin
      rem_d = rem_q - CntW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b1;
      phase_q <= PH_NORMAL;
      err_q   <= ERR_NONE;
      rem_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (s_xfer) begin
        phase_q <= res.phase;
        err_q   <= res.err;
      end
      rem_q <= rem_d;
    end
  end

  // Result burst: load a whole burst, advance one byte per transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q    <= res.bytes;
      bvalid_q <= res.bvalid;
      done_q   <= res.done;
      status_q <= res.status;
    end else if (m_xfer) begin
      buf_q <= {8'h00, buf_q[MaxBytes-1:1]};
    end
  end

  assign m_axis_tvalid = (rem_q != '0);
  assign m_axis_tlast  = (rem_q == CntW'(1));
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tuser  = {status_q, done_q, bvalid_q};

  // Burst counter never exceeds the longest burst
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxBytes))
    else $error("result count out of range");

  // Input is held off while more than one result is still pending
  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q > CntW'(1)) |-> !s_axis_tready)
    else $error("input accepted during a burst");

  // End marker is answered by a lone status result in the next cycle
  a_end_answer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser[1] && m_axis_tlast && !m_axis_tuser[0]))
    else $error("end marker not answered by status result");

  // Scan state returns to reset after the end marker
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=>
      (phase_q == PH_NORMAL && err_q == ERR_NONE))
    else $error("scan state not cleared after end marker");

  // Status result carries no byte
  a_status_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 8'h00))
    else $error("status result with nonzero byte");

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for glob_to_regex_translator
// Streams wildcard patterns into the translator and checks every result
// transfer against a behavioral translator kept in the bench. Directed
// patterns cover each rewrite rule and error case. Random, mostly
// well-formed patterns follow, in both modes, with random stalls on both
// sides.
// ----------------------------------------------------------------------------

module tb;
  import g2r_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 370;
  localparam int unsigned DrainCycles = 4;     // output register plus margin

  // One result transfer as seen on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       done;
    logic [1:0] status;
    logic       last;
  } regex_beat_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] pattern_byte
  logic       s_axis_tlast  = 1'b0;    // end_marker
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic [3:0] m_axis_tuser;            // [0] byte_valid, [1] done_res, [3:2] status
  logic       m_axis_tlast;            // run_last

  // Bench copy of the translator state
  phase_e     scan_ph    = PH_NORMAL;
  logic [1:0] sticky_err = ERR_NONE;
  logic       wc_mode    = 1'b1;

  logic [7:0]  emit_q[$];          // bytes one pattern byte turns into
  regex_beat_t regex_expect_q[$];  // results still owed by the translator
  logic [7:0]  pat_q[$];           // pattern under construction

  int  mismatches = 0;
  int  items_sent = 0;
  int  cycles     = 0;
  int  rx_hold    = 0;
  bit  quiet      = 1'b0;          // no idling on either side while set

  glob_to_regex_translator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Idle length for either side: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // --------------------------------------------------------------------------
  // Behavioral translator
  // --------------------------------------------------------------------------

  // A byte inside a bracket: ']' closes it, '[' is held back for a look at
  // the next byte, anything else is copied.
  function automatic void bracket_char(logic [7:0] c);
    if (c == CH_RBRACK) begin
      emit_q.push_back(c);
      scan_ph = PH_NORMAL;
    end else if (c == CH_LBRACK) begin
      scan_ph = PH_HELD;
    end else begin
      emit_q.push_back(c);
      scan_ph = PH_IN;
    end
  endfunction

  // Advance the bench state by one accepted transfer and queue the results
  // it owes.
  function automatic void translate_item(logic [7:0] c, logic end_mk);
    regex_beat_t beat;
    emit_q.delete();
    if (end_mk) begin
      // Open bracket or pending backslash at the end is an error, unless an
      // earlier one is already latched.
      if (sticky_err == ERR_NONE) begin
        if (scan_ph inside {PH_OPEN, PH_IN, PH_HELD}) sticky_err = ERR_BRACKET;
        else if (scan_ph == PH_ESCAPE) sticky_err = ERR_ESCAPE;
      end
      beat = '{data: 8'h00, bvalid: 1'b0, done: 1'b1, status: sticky_err, last: 1'b1};
      regex_expect_q.push_back(beat);
      scan_ph    = PH_NORMAL;
      sticky_err = ERR_NONE;
      return;
    end
    // After an error every byte is dropped until the end marker
    if (sticky_err != ERR_NONE) return;

    if (!wc_mode) begin
      // Copy through; the scan phase stays where it was
      emit_q.push_back(c);
    end else begin
      case (scan_ph)
        PH_ESCAPE: begin
          emit_q.push_back(CH_BSLASH);
          emit_q.push_back(c);
          scan_ph = PH_NORMAL;
        end
        PH_OPEN: begin
          if (c == CH_RBRACK) sticky_err = ERR_BRACKET;
          else bracket_char(c);
        end
        PH_IN: bracket_char(c);
        PH_HELD: begin
          if (c == CH_DOT || c == CH_EQ || c == CH_COLON) begin
            // Inner class opener: neutralize it as a literal '['
            emit_q.push_back(CH_LBRACK);
            emit_q.push_back(CH_DOT);
            emit_q.push_back(CH_LBRACK);
            emit_q.push_back(CH_DOT);
            emit_q.push_back(CH_RBRACK);
            emit_q.push_back(c);
            scan_ph = PH_IN;
          end else begin
            emit_q.push_back(CH_LBRACK);
            bracket_char(c);
          end
        end
        default: begin
          scan_ph = PH_NORMAL;
          case (c)
            CH_QMARK: emit_q.push_back(CH_DOT);
            CH_STAR: begin
              emit_q.push_back(CH_DOT);
              emit_q.push_back(CH_STAR);
            end
            CH_LBRACK: begin
              emit_q.push_back(c);
              scan_ph = PH_OPEN;
            end
            CH_BSLASH: scan_ph = PH_ESCAPE;
            CH_CARET, CH_DOT, CH_DOLLAR, CH_LPAREN, CH_RPAREN,
            CH_PIPE, CH_PLUS, CH_LBRACE: begin
              emit_q.push_back(CH_BSLASH);
              emit_q.push_back(c);
            end
            default: emit_q.push_back(c);
          endcase
        end
      endcase
    end

    foreach (emit_q[k]) begin
      beat = '{data: emit_q[k], bvalid: 1'b1, done: 1'b0, status: ERR_NONE,
               last: (k == emit_q.size() - 1)};
      regex_expect_q.push_back(beat);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold       <= pick_gap();
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest outstanding expectation
  always @(posedge clk_i) begin : result_check
    regex_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (regex_expect_q.size() == 0) begin
        $error("unexpected result: tdata %0h tuser %0h tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = regex_expect_q.pop_front();
        check_field("out_byte",   want.data,   m_axis_tdata);
        check_field("byte_valid", want.bvalid, m_axis_tuser[0]);
        check_field("done_res",   want.done,   m_axis_tuser[1]);
        check_field("status",     want.status, m_axis_tuser[3:2]);
        check_field("run_last",   want.last,   m_axis_tlast);
      end
    end
  end

  // Hard stop in case the translator hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Pattern side
  // --------------------------------------------------------------------------

  // Offer one transfer and hold it until accepted. Called at a rising edge;
  // returns at a rising edge. With no gap the valid stays high for the next
  // transfer.
  task automatic send_item(logic [7:0] c, logic end_mk);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= end_mk;
    do @(posedge clk_i); while (!s_axis_tready);
    translate_item(c, end_mk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // End marker; its data byte is don't-care, so randomize it
  task automatic send_end();
    send_item(8'($urandom), 1'b1);
  endtask

  // Drop valid and hold off until every owed result is out, then allow the
  // translator to finish a transfer that owes nothing.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (regex_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(logic mode);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    wc_mode      = mode;
  endtask

  // --------------------------------------------------------------------------
  // Random pattern construction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] pick_char();
    string glyphs;
    glyphs = "?*[]\\.=:^$()|+{a0";
    if ($urandom_range(0, 1) == 0) return glyphs[$urandom_range(0, glyphs.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Append one token: a literal, a wildcard, an escape pair, a bracket
  // expression (sometimes empty, unterminated or holding an inner class), or
  // a raw noise byte.
  function automatic void add_token();
    int    r;
    int    n;
    string openers;
    openers = ".=:";
    r = $urandom_range(0, 99);
    if (r < 30) begin
      pat_q.push_back(pick_char());
    end else if (r < 40) begin
      pat_q.push_back($urandom_range(0, 1) ? CH_STAR : CH_QMARK);
    end else if (r < 50) begin
      pat_q.push_back(CH_BSLASH);
      pat_q.push_back(pick_char());
    end else if (r < 85) begin
      pat_q.push_back(CH_LBRACK);
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          pat_q.push_back(CH_LBRACK);
          if ($urandom_range(0, 3) != 0) pat_q.push_back(openers[$urandom_range(0, 2)]);
          else pat_q.push_back(pick_char());
        end
        pat_q.push_back(pick_char());
      end
      if ($urandom_range(0, 9) != 0) pat_q.push_back(CH_RBRACK);
    end else begin
      pat_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every wildcard and metacharacter rewrite, plus the byte extremes
  task automatic test_wildcard_ops();
    set_mode(1'b1);
    send_text("?*^.$()|+{");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_end();
  endtask

  // Escaped star, then a bracket with each inner class opener, a held '['
  // before an ordinary byte, and the closing ']'
  task automatic test_brackets();
    send_text("\\*[[.[=[:[x]");
    send_end();
  endtask

  // Empty bracket (later bytes dropped), open bracket, held '[' and pending
  // backslash at the end marker
  task automatic test_error_cases();
    send_text("[]x");
    send_end();
    send_text("[a");
    send_end();
    send_text("[[");
    send_end();
    send_text("\\");
    send_end();
  endtask

  // Copy-through, and a mode change in the middle of a bracket that picks up
  // the translation where it left off
  task automatic test_passthrough();
    quiet = 1'b1;
    set_mode(1'b0);
    send_text("*[\\?");
    send_end();
    set_mode(1'b1);
    send_text("[");
    set_mode(1'b0);
    send_text("?");
    set_mode(1'b1);
    send_text("]");
    send_end();
    quiet = 1'b0;
  endtask

  task automatic test_random_patterns();
    int start;
    int pats;
    int ntok;
    start = items_sent;
    pats  = 0;
    while (items_sent - start < RandomItems) begin
      quiet = ($urandom_range(0, 99) < 15);
      // Hold the sender once until the result side has fully drained
      if (pats == 25) wait_idle();
      if ($urandom_range(0, 99) < 8) set_mode($urandom_range(0, 3) != 0);
      pat_q.delete();
      ntok = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      repeat (ntok) add_token();
      foreach (pat_q[i]) begin
        if ($urandom_range(0, 99) < 2) set_mode(!wc_mode);
        send_item(pat_q[i], 1'b0);
      end
      send_end();
      pats++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wildcard_ops();
    test_brackets();
    test_error_cases();
    test_passthrough();
    test_random_patterns();

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
